FILE: src/dtyp_pkg.sv
`default_nettype none
package dtyp_pkg;
   localparam int CoordWidth = 24;
   localparam int AngleFracBits = 7;
   localparam int Stages = 16;
   localparam int GuardBits = 8;
   localparam int AccFrac = 24;
   // Working width: coordinate plus guard bits plus CORDIC growth and sign.
   localparam int WorkWidth = CoordWidth + GuardBits + 3;
   localparam int AccWidth = 35;
   localparam int AngleWidth = 16;
   localparam int InvGainQ20 = 636751;

   typedef logic signed [WorkWidth-1:0] work_type;
   typedef logic signed [AccWidth-1:0] acc_type;
   typedef logic [AngleWidth-1:0] angle_type;

   // Sideband that rides along the pipeline with each vector.
   typedef struct packed {
      logic vertical;
      logic z_pos;
      logic x_zero;
      logic y_pos;
   } flags_type;

   localparam acc_type Acc180 = acc_type'(64'sd180 <<< AccFrac);
   localparam angle_type Full = angle_type'(360 << AngleFracBits);
   localparam angle_type Deg90 = angle_type'(90 << AngleFracBits);
   localparam angle_type Deg270 = angle_type'(270 << AngleFracBits);

   // Arctangent of 2^-i in degrees, units of 2^-24 degree.
   function automatic acc_type atan_lut(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0: v = 754974720;  5'd1: v = 445687602;  5'd2: v = 235489089;
         5'd3: v = 119537938;  5'd4: v = 60000934;   5'd5: v = 30029717;
         5'd6: v = 15018523;   5'd7: v = 7509720;    5'd8: v = 3754917;
         5'd9: v = 1877466;    5'd10: v = 938734;    5'd11: v = 469367;
         5'd12: v = 234684;    5'd13: v = 117342;    5'd14: v = 58671;
         5'd15: v = 29335;     5'd16: v = 14668;     5'd17: v = 7334;
         5'd18: v = 3667;      5'd19: v = 1833;      5'd20: v = 917;
         5'd21: v = 458;       5'd22: v = 229;       5'd23: v = 115;
         5'd24: v = 57;        5'd25: v = 29;        5'd26: v = 14;
         5'd27: v = 7;         5'd28: v = 4;         5'd29: v = 2;
         5'd30: v = 1;         default: v = 0;
      endcase
      return acc_type'({3'b000, v});
   endfunction

   // Round an accumulator half up to the output angle unit and wrap negatives.
   function automatic angle_type round_wrap(input acc_type a);
      acc_type r;
      r = (a + acc_type'(1 <<< (AccFrac - 1 - AngleFracBits))) >>> (AccFrac - AngleFracBits);
      if (r < 0) begin
         r = r + acc_type'(Full);
      end
      return r[AngleWidth-1:0];
   endfunction
endpackage
`default_nettype wire

FILE: src/direction_to_yaw_pitch_unit.sv
`default_nettype none
// Direction to yaw/pitch converter.
// The req_ channel carries one direction vector per transaction; the rsp_
// channel returns one pair of angles per vector, in 1/128 degree units.
// Yaw is atan2(y, x) in 0..360; pitch is 360 minus the wrapped elevation, so up to 360.
// The pipeline has 2*16 + 3 = 35 register stages: two 16-stage CORDIC vectoring
// pipelines, one register on entry, a gain multiply and rounding stage, and
// the output register. The entry register loads at the accepting edge, and
// rsp_tvalid rises once the vector has passed through all of these stages.
// Throughput is one vector per cycle. The whole pipeline advances together:
// when the receiver stalls with a result waiting, req_tready falls and every
// stage holds, so nothing is lost or repeated. Whenever the output register
// is empty or being taken, a new vector is accepted.
// Reset clears all valid bits; no result is pending afterwards.
module direction_to_yaw_pitch_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // tdata: delta_x [23:0], delta_y [47:24], delta_z [71:48]
   input wire logic [71:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // tdata: pitch_angle [15:0], yaw_angle [31:16]
   output logic [31:0] rsp_tdata
);
   localparam int W = dtyp_pkg::WorkWidth;
   localparam int CW = dtyp_pkg::CoordWidth;
   localparam int N = dtyp_pkg::Stages;

   logic advance;
   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   logic signed [CW-1:0] dx, dy, dz;
   assign dx = req_tdata[CW-1:0];
   assign dy = req_tdata[2*CW-1:CW];
   assign dz = req_tdata[3*CW-1:2*CW];

   // Entry stage: guard scaling, left half plane fold and flags.
   logic e_valid_ff;
   dtyp_pkg::work_type e_x_ff, e_y_ff, e_z_ff;
   dtyp_pkg::acc_type e_acc_ff;
   dtyp_pkg::flags_type e_flags_ff;
   dtyp_pkg::work_type sx, sy;
   assign sx = dtyp_pkg::work_type'(dx) <<< dtyp_pkg::GuardBits;
   assign sy = dtyp_pkg::work_type'(dy) <<< dtyp_pkg::GuardBits;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= req_tvalid;
      end
      if (advance) begin
         e_x_ff <= dx[CW-1] ? -sx : sx;
         e_y_ff <= dx[CW-1] ? -sy : sy;
         e_acc_ff <= dx[CW-1] ? dtyp_pkg::Acc180 : '0;
         e_z_ff <= dtyp_pkg::work_type'(dz) <<< dtyp_pkg::GuardBits;
         e_flags_ff.vertical <= (dx == '0) && (dy == '0);
         e_flags_ff.z_pos <= !dz[CW-1] && (dz != '0);
         e_flags_ff.x_zero <= dx == '0;
         e_flags_ff.y_pos <= !dy[CW-1] && (dy != '0);
      end
   end

   // Sideband delay lines alongside the first CORDIC pass.
   dtyp_pkg::work_type z_dl_ff [N];
   dtyp_pkg::flags_type f1_dl_ff [N];
   always_ff @(posedge clock) begin
      if (advance) begin
         z_dl_ff[0] <= e_z_ff;
         f1_dl_ff[0] <= e_flags_ff;
         for (int i = 1; i < N; i++) begin
            z_dl_ff[i] <= z_dl_ff[i-1];
            f1_dl_ff[i] <= f1_dl_ff[i-1];
         end
      end
   end

   logic c1_valid;
   dtyp_pkg::work_type c1_x;
   dtyp_pkg::acc_type c1_acc;
   dtyp_cordic u_yaw (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(e_valid_ff), .in_x(e_x_ff), .in_y(e_y_ff), .in_acc(e_acc_ff),
      .out_valid(c1_valid), .out_x(c1_x), .out_acc(c1_acc)
   );

   // Gain compensation and yaw rounding.
   logic g_valid_ff;
   dtyp_pkg::work_type g_r_ff, g_z_ff;
   dtyp_pkg::angle_type g_yaw_ff;
   dtyp_pkg::flags_type g_flags_ff;
   logic [W+20-1:0] prod;
   dtyp_pkg::angle_type yaw_in;
   assign prod = (W+20)'(unsigned'(c1_x)) * (W+20)'(dtyp_pkg::InvGainQ20)
                 + (W+20)'(1 << 19);
   always_comb begin
      if (f1_dl_ff[N-1].vertical) begin
         yaw_in = '0;
      end else if (f1_dl_ff[N-1].x_zero) begin
         yaw_in = f1_dl_ff[N-1].y_pos ? dtyp_pkg::Deg90 : dtyp_pkg::Deg270;
      end else begin
         yaw_in = dtyp_pkg::round_wrap(c1_acc);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (advance) begin
         g_valid_ff <= c1_valid;
      end
      if (advance) begin
         g_r_ff <= dtyp_pkg::work_type'(prod[W+20-1:20]);
         g_z_ff <= z_dl_ff[N-1];
         g_yaw_ff <= yaw_in;
         g_flags_ff <= f1_dl_ff[N-1];
      end
   end

   dtyp_pkg::angle_type yaw_dl_ff [N];
   dtyp_pkg::flags_type f2_dl_ff [N];
   always_ff @(posedge clock) begin
      if (advance) begin
         yaw_dl_ff[0] <= g_yaw_ff;
         f2_dl_ff[0] <= g_flags_ff;
         for (int i = 1; i < N; i++) begin
            yaw_dl_ff[i] <= yaw_dl_ff[i-1];
            f2_dl_ff[i] <= f2_dl_ff[i-1];
         end
      end
   end

   logic c2_valid;
   dtyp_pkg::work_type c2_x;
   dtyp_pkg::acc_type c2_acc;
   dtyp_cordic u_pitch (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(g_valid_ff), .in_x(g_r_ff), .in_y(g_z_ff), .in_acc('0),
      .out_valid(c2_valid), .out_x(c2_x), .out_acc(c2_acc)
   );

   // Pitch rounding, inversion and output register.
   dtyp_pkg::angle_type pitch_in, elev;
   always_comb begin
      if (f2_dl_ff[N-1].vertical) begin
         elev = f2_dl_ff[N-1].z_pos ? dtyp_pkg::Deg90 : dtyp_pkg::Deg270;
      end else begin
         elev = dtyp_pkg::round_wrap(c2_acc);
      end
      pitch_in = dtyp_pkg::Full - elev;
   end

   logic out_valid_ff;
   logic [31:0] out_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= c2_valid;
      end
      if (advance) begin
         out_data_ff <= {yaw_dl_ff[N-1], pitch_in};
      end
   end
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

   // Checks on the pipeline control, the angle range and the magnitude sign.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output space");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] <= dtyp_pkg::Full && rsp_tdata[31:16] < dtyp_pkg::Full)
      else $error("angle out of range");
   a_unused: assert property (@(posedge clock) disable iff (reset)
      c2_valid |-> !c2_x[W-1])
      else $error("magnitude negative");
endmodule
`default_nettype wire

FILE: src/dtyp_cordic.sv
`default_nettype none
// One pipelined CORDIC vectoring pass, one micro-rotation per stage.
module dtyp_cordic (
   input wire logic clock,
   input wire logic reset,
   input wire logic advance,
   input wire logic in_valid,
   input wire dtyp_pkg::work_type in_x,
   input wire dtyp_pkg::work_type in_y,
   input wire dtyp_pkg::acc_type in_acc,
   output logic out_valid,
   output dtyp_pkg::work_type out_x,
   output dtyp_pkg::acc_type out_acc
);
   localparam int N = dtyp_pkg::Stages;
   dtyp_pkg::work_type x_ff [1:N];
   dtyp_pkg::work_type y_ff [1:N];
   dtyp_pkg::acc_type a_ff [1:N];
   logic [N:1] v_ff;

   for (genvar i = 0; i < N; i++) begin : g_stage
      dtyp_pkg::work_type x_cur, y_cur, x_in, y_in;
      dtyp_pkg::acc_type a_cur, a_in;
      logic v_cur;
      // The first stage takes the pass inputs, later ones the previous stage.
      if (i == 0) begin : g_first
         assign x_cur = in_x;
         assign y_cur = in_y;
         assign a_cur = in_acc;
         assign v_cur = in_valid;
      end else begin : g_next
         assign x_cur = x_ff[i];
         assign y_cur = y_ff[i];
         assign a_cur = a_ff[i];
         assign v_cur = v_ff[i];
      end
      // Rotate toward the x axis by the stage's fixed angle.
      always_comb begin
         if (!y_cur[dtyp_pkg::WorkWidth-1]) begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            a_in = a_cur + dtyp_pkg::atan_lut(5'(i));
         end else begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            a_in = a_cur - dtyp_pkg::atan_lut(5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (advance) begin
            v_ff[i+1] <= v_cur;
         end
         if (advance) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            a_ff[i+1] <= a_in;
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_x = x_ff[N];
   assign out_acc = a_ff[N];
endmodule
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

// Scoreboard that predicts the angle pair for every accepted vector.
class angle_scoreboard;
   logic [15:0] pitch_q[$];
   logic [15:0] yaw_q[$];
   int errors;
   int shown;

   static function longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   static function longint atan_entry(int i);
      longint tbl[16] = '{754974720, 445687602, 235489089, 119537938, 60000934,
                          30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                          469367, 234684, 117342, 58671, 29335};
      return tbl[i];
   endfunction

   // Vectoring pass that drives b toward zero and sums the rotation angle.
   static function void rotate_to_axis(inout longint a, inout longint b,
                                       inout longint ang);
      longint da, db;
      for (int i = 0; i < 16; i++) begin
         da = shr_floor(a, i);
         db = shr_floor(b, i);
         if (b >= 0) begin
            a += db; b -= da; ang += atan_entry(i);
         end else begin
            a -= db; b += da; ang -= atan_entry(i);
         end
      end
   endfunction

   static function longint round_deg(longint a);
      return shr_floor(a + (longint'(1) << 16), 17);
   endfunction

   // Work out the expected angles for one accepted vector.
   function void note_vector(logic [71:0] data);
      longint x, y, z, cx, cy, acc, r, cz, acc2, yaw, pitch, res;
      longint full;
      full = 360 * 128;
      x = longint'($signed(data[23:0]));
      y = longint'($signed(data[47:24]));
      z = longint'($signed(data[71:48]));
      if (x == 0 && y == 0) begin
         yaw = 0;
         pitch = (z > 0) ? 90 * 128 : 270 * 128;
      end else begin
         cx = x * 256; cy = y * 256; acc = 0; acc2 = 0;
         if (cx < 0) begin
            cx = -cx; cy = -cy; acc = longint'(180) << 24;
         end
         rotate_to_axis(cx, cy, acc);
         if (x == 0) yaw = (y > 0) ? 90 * 128 : 270 * 128;
         else yaw = round_deg(acc);
         if (yaw < 0) yaw += full;
         r = (cx * 636751 + (longint'(1) << 19)) >>> 20;
         cz = z * 256;
         rotate_to_axis(r, cz, acc2);
         pitch = round_deg(acc2);
         if (pitch < 0) pitch += full;
      end
      res = full - pitch;
      if (res > full) res -= full;
      if (res < 0) res += full;
      pitch_q.push_back(res[15:0]);
      yaw_q.push_back(yaw[15:0]);
   endfunction

   // Compare one result transaction with the oldest expectation.
   function void check_angles(logic [31:0] data);
      logic [15:0] ep, ey;
      if (pitch_q.size() == 0) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("unexpected result %h", data);
         end
         return;
      end
      ep = pitch_q.pop_front();
      ey = yaw_q.pop_front();
      if (data[15:0] !== ep || data[31:16] !== ey) begin
         errors++;
         if (shown < 10) begin
            shown++;
            $display("mismatch: pitch exp %0d got %0d, yaw exp %0d got %0d",
                     ep, data[15:0], ey, data[31:16]);
         end
      end
   endfunction
endclass

module testbench;
   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   angle_scoreboard board = new();

   direction_to_yaw_pitch_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #4 clock = ~clock;

   // Receiver side: random stalls and result checking.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_angles(rsp_tdata);
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Offer one vector, with a random idle gap first, and wait for acceptance.
   task automatic send_vector(logic [23:0] x, logic [23:0] y, logic [23:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_vector({z, y, x});
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(5))
         0: return 24'(int'($urandom_range(8)) - 4);
         1: return 24'h800000;
         2: return 24'h7FFFFF;
         3: return 24'($urandom_range(511)) - 24'd256;
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      logic [23:0] ext[5];
      ext = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000};
      repeat (10) @(posedge clock);
      reset <= 0;
      // Directed: vertical cases, axes, left half plane and field extremes.
      send_vector(24'd0, 24'd0, 24'd0);
      send_vector(24'd0, 24'd0, 24'd5);
      send_vector(24'd0, 24'd0, 24'hFFFFFB);
      send_vector(24'd0, 24'd7, 24'd3);
      send_vector(24'd0, 24'hFFFFF9, 24'd3);
      send_vector(24'hFFFFF0, 24'h000010, 24'd0);
      send_vector(24'hFFFFF0, 24'hFFFFF0, 24'h000020);
      send_vector(24'd100, 24'd0, 24'd0);
      for (int i = 0; i < 5; i++)
         for (int j = 0; j < 3; j++)
            send_vector(ext[i], ext[(i + j + 1) % 5], ext[(i + 2 * j) % 5]);
      // Random vectors across the four idling phases.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 65 : (ph == 3) ? 13 : 0;
         recv_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 13 : 0;
         for (int n = 0; n < 435; n++)
            send_vector(rand_coord(), rand_coord(), rand_coord());
      end
      req_tvalid <= 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (board.pitch_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4000000;
      $display("testbench: FAIL");
      $finish;
   end
endmodule

`default_nettype wire

FILE: filelist.f
src/dtyp_pkg.sv
src/dtyp_cordic.sv
src/direction_to_yaw_pitch_unit.sv
bench/testbench.sv
